@@ rtl/sha256_stream_hash_assert.svh @@
// Assertion macros for the sha256 checker.
`ifndef SHA256_STREAM_HASH_ASSERT_SVH
`define SHA256_STREAM_HASH_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SHA256_CHK_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sha256 same-cycle check failed");

// next-cycle implication
`define SHA256_CHK_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sha256 next-cycle check failed");

`endif

@@ rtl/sha256_pkg.sv @@
`default_nettype none
package sha256_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} msg_item_t;

	typedef struct packed {
		logic [31:0] hash_word;
		logic [2:0]  word_index;
		logic        last_word;
	} dig_item_t;

	// word w holds bytes 4w..4w+3, byte 4w in the top lane
	typedef logic [15:0][31:0] blk_words_t;

	typedef struct packed {
		blk_words_t words;
		logic       last;
	} blk_t;

	localparam logic [7:0] PadMark = 8'h80;
	localparam logic [5:0] LastByte = 6'd63;
	localparam logic [5:0] MaxFitFill = 6'd55;

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		logic [63:0] d;
		d = {x, x} >> n;
		return d[31:0];
	endfunction

	function automatic logic [31:0] big_sig0(input logic [31:0] x);
		return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] x);
		return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
	endfunction

	function automatic logic [31:0] small_sig0(input logic [31:0] x);
		return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sig1(input logic [31:0] x);
		return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
	endfunction

endpackage
`default_nettype wire

@@ rtl/sha256_front.sv @@
`default_nettype none
module sha256_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               msg_valid,
	output logic                    msg_stall,
	input  wire sha256_pkg::msg_item_t msg,
	output logic                    push,
	output sha256_pkg::blk_t        push_blk,
	input  wire logic               q_full
);
	import sha256_pkg::*;

	typedef enum logic [2:0] {
		F_IN  = 3'b001,
		F_PAD = 3'b010,
		F_LEN = 3'b100
	} fst_t;

	fst_t       st_q;
	logic [5:0] fill_q;
	logic [60:0] cnt_q;
	blk_words_t buf_q;

	logic       take;
	logic       fits;
	blk_words_t merged;
	blk_words_t padded;
	logic [63:0] bit_len;

	assign msg_stall = (st_q != F_IN) || q_full;
	assign take      = msg_valid && !msg_stall;
	assign fits      = fill_q <= MaxFitFill;
	assign bit_len   = {cnt_q, 3'b000};

	always_comb begin
		merged = buf_q;
		merged[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] = msg.data_byte;
	end

	// 0x80 at fill, zeros after, length in last two words if it fits; F_LEN: zeros, length
	always_comb begin
		logic [5:0] idx;
		for (int w = 0; w < 16; w++) begin
			for (int b = 0; b < 4; b++) begin
				idx = 6'(w * 4 + b);
				if (st_q == F_LEN || idx > fill_q) begin
					padded[w][(3 - b) * 8 +: 8] = 8'h00;
				end else if (idx == fill_q) begin
					padded[w][(3 - b) * 8 +: 8] = PadMark;
				end else begin
					padded[w][(3 - b) * 8 +: 8] = buf_q[w][(3 - b) * 8 +: 8];
				end
			end
		end
		if (st_q == F_LEN || fits) begin
			padded[14] = bit_len[63:32];
			padded[15] = bit_len[31:0];
		end
	end

	always_comb begin
		push     = 1'b0;
		push_blk = '{words: merged, last: 1'b0};
		unique case (st_q)
			F_IN: begin
				push = take && msg.has_byte && (fill_q == LastByte);
			end
			F_PAD: begin
				push     = !q_full;
				push_blk = '{words: padded, last: fits};
			end
			F_LEN: begin
				push     = !q_full;
				push_blk = '{words: padded, last: 1'b1};
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (take && msg.has_byte) begin
			buf_q <= merged;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= F_IN;
			fill_q <= '0;
			cnt_q  <= '0;
		end else begin
			unique case (st_q)
				F_IN: begin
					if (take) begin
						if (msg.has_byte) begin
							// 6-bit fill wraps to zero as the full block leaves
							fill_q <= fill_q + 6'd1;
							cnt_q  <= cnt_q + 61'd1;
						end
						if (msg.end_of_message) begin
							st_q <= F_PAD;
						end
					end
				end
				F_PAD: begin
					if (!q_full) begin
						if (fits) begin
							st_q   <= F_IN;
							fill_q <= '0;
							cnt_q  <= '0;
						end else begin
							st_q <= F_LEN;
						end
					end
				end
				F_LEN: begin
					if (!q_full) begin
						st_q   <= F_IN;
						fill_q <= '0;
						cnt_q  <= '0;
					end
				end
				default: begin
					st_q <= F_IN;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/sha256_fifo.sv @@
`default_nettype none
module sha256_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire sha256_pkg::blk_t push_blk,
	output logic                 full,
	input  wire logic            pop,
	output logic                 head_valid,
	output sha256_pkg::blk_t     head
);
	import sha256_pkg::*;

	blk_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full       = cnt_q == 2'd2;
	assign head_valid = cnt_q != 2'd0;
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_blk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/sha256_core.sv @@
`default_nettype none
module sha256_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            head_valid,
	input  wire sha256_pkg::blk_t head,
	output logic                 pop,
	output logic                 dig_valid,
	input  wire logic            dig_stall,
	output sha256_pkg::dig_item_t dig
);
	import sha256_pkg::*;

	typedef enum logic [3:0] {
		C_IDLE = 4'b0001,
		C_RUN  = 4'b0010,
		C_FOLD = 4'b0100,
		C_OUT  = 4'b1000
	} cst_t;

	cst_t              st_q;
	logic [7:0][31:0]  h_q;
	logic [7:0][31:0]  v_q;
	blk_words_t        w_q;
	logic [5:0]        rnd_q;
	logic              last_q;
	logic [2:0]        idx_q;

	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] w_new;

	always_comb begin
		t1 = v_q[7] + big_sig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ ROUND_K[rnd_q] + w_q[0];
		t2 = big_sig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		// schedule word i+16 from the 16-word window
		w_new = w_q[0] + small_sig0(w_q[1]) + w_q[9] + small_sig1(w_q[14]);
	end

	assign pop       = (st_q == C_IDLE) && head_valid;
	assign dig_valid = st_q == C_OUT;
	assign dig       = '{hash_word: h_q[idx_q], word_index: idx_q,
		last_word: (idx_q == 3'd7)};

	always_ff @(posedge clk) begin
		if (pop) begin
			w_q <= head.words;
			v_q <= h_q;
		end else if (st_q == C_RUN) begin
			w_q <= {w_new, w_q[15:1]};
			v_q <= {v_q[6:4], v_q[3] + t1, v_q[2:0], t1 + t2};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= C_IDLE;
			rnd_q  <= '0;
			last_q <= 1'b0;
			idx_q  <= '0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= INIT_H[i];
			end
		end else begin
			unique case (st_q)
				C_IDLE: begin
					if (head_valid) begin
						st_q   <= C_RUN;
						rnd_q  <= '0;
						last_q <= head.last;
					end
				end
				C_RUN: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						st_q <= C_FOLD;
					end
				end
				C_FOLD: begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] + v_q[i];
					end
					idx_q <= '0;
					st_q  <= last_q ? C_OUT : C_IDLE;
				end
				C_OUT: begin
					if (!dig_stall) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							st_q <= C_IDLE;
							for (int i = 0; i < 8; i++) begin
								h_q[i] <= INIT_H[i];
							end
						end
					end
				end
				default: begin
					st_q <= C_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/sha256_stream_hash.sv @@
// channel | dir | handshake             | beat payload
// msg     | in  | msg_valid / msg_stall | sha256_pkg::msg_item_t (one byte and/or end mark)
// dig     | out | dig_valid / dig_stall | sha256_pkg::dig_item_t (one digest word)
//
// Front takes one byte beat per cycle while the two-block queue has room and no padding is pending.
// Core handles one block at a time: load, 64 rounds, fold into the hash words.
// An end beat adds one or two padding blocks, then 8 digest beats, one per
// cycle that dig_stall is low; msg_stall stays high from the end beat until padding is queued.
// Async reset restores the initial hash words and empties the queue; no clearing pass.
`default_nettype none
module sha256_stream_hash (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  msg_valid,
	output logic                       msg_stall,
	input  wire sha256_pkg::msg_item_t msg,
	output logic                       dig_valid,
	input  wire logic                  dig_stall,
	output sha256_pkg::dig_item_t      dig
);
	import sha256_pkg::*;

	logic push;
	blk_t push_blk;
	logic q_full;
	logic pop;
	logic head_valid;
	blk_t head;

	sha256_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg       (msg),
		.push      (push),
		.push_blk  (push_blk),
		.q_full    (q_full)
	);

	sha256_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_blk   (push_blk),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	sha256_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.dig_valid  (dig_valid),
		.dig_stall  (dig_stall),
		.dig        (dig)
	);

endmodule
`default_nettype wire

@@ rtl/sha256_chk.sv @@
`default_nettype none
`include "sha256_stream_hash_assert.svh"
module sha256_chk (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  msg_valid,
	input wire logic                  msg_stall,
	input wire sha256_pkg::msg_item_t msg,
	input wire logic                  dig_valid,
	input wire logic                  dig_stall,
	input wire sha256_pkg::dig_item_t dig
);
	import sha256_pkg::*;

	`SHA256_CHK_IMP(a_last_flag, dig_valid, dig.last_word == (dig.word_index == 3'd7))
	`SHA256_CHK_NXT(a_idx_step, dig_valid && !dig_stall && !dig.last_word, dig_valid && (dig.word_index == 3'($past(dig.word_index) + 3'd1)))
	`SHA256_CHK_NXT(a_end_holds, msg_valid && !msg_stall && msg.end_of_message, msg_stall)
	`SHA256_CHK_NXT(a_dig_hold, dig_valid && dig_stall, dig_valid && $stable(dig))

endmodule

bind sha256_stream_hash sha256_chk u_chk (.*);
`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import sha256_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned TAIL_CYCLES = 300;
	localparam int unsigned PHASE_BEATS = 20;
	localparam int unsigned MAX_REPORTS = 10;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam int unsigned LEN_FIELD_AT = 56;
	localparam int unsigned BLOCK_LEN = 64;
	localparam int unsigned BOUNDARY_LEN [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

	localparam logic [31:0] START_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      msg_valid = 1'b0;
	logic      msg_stall;
	msg_item_t msg = '0;
	logic      dig_valid;
	logic      dig_stall = 1'b0;
	dig_item_t dig;

	int unsigned sender_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned random_beats = 0;

	// hash state as the block should hold it
	logic [31:0] model_h [8];
	logic [7:0]  model_blk [64];
	int unsigned model_fill;
	logic [60:0] model_len;
	dig_item_t   digest_q [$];

	sha256_stream_hash DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg       (msg),
		.dig_valid (dig_valid),
		.dig_stall (dig_stall),
		.dig       (dig)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(negedge clk) begin
		dig_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void restart_hash();
		for (int i = 0; i < 8; i++)
			model_h[i] = START_H[i];
		for (int i = 0; i < 64; i++)
			model_blk[i] = 8'h00;
		model_fill = 0;
		model_len = '0;
	endfunction

	function automatic void fold_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] s0, s1, t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {model_blk[4*i], model_blk[4*i+1], model_blk[4*i+2], model_blk[4*i+3]};
		for (int i = 16; i < 64; i++) begin
			s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		for (int i = 0; i < 8; i++)
			v[i] = model_h[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + RND_K[i] + w[i];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			model_h[i] = model_h[i] + v[i];
	endfunction

	// update the model with one accepted beat; an end beat queues the digest
	function automatic void absorb_beat(input msg_item_t it);
		logic [63:0] bit_len;
		dig_item_t d;
		if (it.has_byte) begin
			model_blk[model_fill] = it.data_byte;
			model_fill++;
			model_len++;
			if (model_fill == BLOCK_LEN) begin
				fold_block();
				model_fill = 0;
			end
		end
		if (!it.end_of_message)
			return;
		model_blk[model_fill] = PAD_BYTE;
		model_fill++;
		// no room for the length field: spill into an extra block
		if (model_fill > LEN_FIELD_AT) begin
			while (model_fill < BLOCK_LEN) begin
				model_blk[model_fill] = 8'h00;
				model_fill++;
			end
			fold_block();
			model_fill = 0;
		end
		while (model_fill < LEN_FIELD_AT) begin
			model_blk[model_fill] = 8'h00;
			model_fill++;
		end
		bit_len = {model_len, 3'b000};
		for (int i = 0; i < 8; i++)
			model_blk[LEN_FIELD_AT + i] = bit_len[63 - 8*i -: 8];
		fold_block();
		for (int i = 0; i < 8; i++) begin
			d.hash_word = model_h[i];
			d.word_index = i[2:0];
			d.last_word = (i == 7);
			digest_q.push_back(d);
		end
		restart_hash();
	endfunction

	task automatic note_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	always @(posedge clk) begin
		dig_item_t want;
		if (arst_n && dig_valid && !dig_stall) begin
			if (digest_q.size() == 0) begin
				note_mismatch($sformatf("unexpected word %h idx %0d last %0b",
					dig.hash_word, dig.word_index, dig.last_word));
			end else begin
				want = digest_q.pop_front();
				if (dig.hash_word !== want.hash_word)
					note_mismatch($sformatf("hash_word exp %h got %h (idx %0d)",
						want.hash_word, dig.hash_word, want.word_index));
				if (dig.word_index !== want.word_index)
					note_mismatch($sformatf("word_index exp %0d got %0d",
						want.word_index, dig.word_index));
				if (dig.last_word !== want.last_word)
					note_mismatch($sformatf("last_word exp %0b got %0b (idx %0d)",
						want.last_word, dig.last_word, want.word_index));
			end
		end
	end

	// entered and left at a falling edge; valid stays high after the beat
	task automatic send_beat(input logic [7:0] b, input logic hb, input logic eom);
		msg_item_t it;
		while ($urandom_range(99) < sender_idle_pct) begin
			msg_valid <= 1'b0;
			msg <= msg_item_t'(10'($urandom));
			@(negedge clk);
		end
		it.data_byte = b;
		it.has_byte = hb;
		it.end_of_message = eom;
		msg <= it;
		msg_valid <= 1'b1;
		do
			@(posedge clk);
		while (msg_stall);
		absorb_beat(it);
		@(negedge clk);
	endtask

	task automatic send_message(input int unsigned len, input bit merge_end);
		for (int unsigned k = 0; k < len; k++) begin
			// beats with neither byte nor end should be ignored
			if ($urandom_range(9) == 0)
				send_beat(8'($urandom), 1'b0, 1'b0);
			send_beat(8'($urandom), 1'b1, merge_end && (k == len - 1));
		end
		if (len == 0 || !merge_end)
			send_beat(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic wait_drained(input int unsigned tail);
		msg_valid <= 1'b0;
		while (digest_q.size() != 0)
			@(negedge clk);
		repeat (tail) @(negedge clk);
	endtask

	task automatic test_empty_message();
		send_beat(8'h00, 1'b0, 1'b1);
		send_beat(8'hff, 1'b0, 1'b1);
	endtask

	task automatic test_short_messages();
		// "abc" with the end on the last byte
		send_beat(8'h61, 1'b1, 1'b0);
		send_beat(8'h62, 1'b1, 1'b0);
		send_beat(8'h63, 1'b1, 1'b1);
		send_beat(8'hff, 1'b1, 1'b1);
		send_beat(8'h00, 1'b1, 1'b0);
		send_beat(8'h5a, 1'b0, 1'b1);
	endtask

	task automatic test_ignored_beats();
		send_beat(8'hff, 1'b0, 1'b0);
		send_beat(8'h01, 1'b1, 1'b0);
		send_beat(8'h00, 1'b0, 1'b0);
		send_beat(8'hfe, 1'b1, 1'b0);
		send_beat(8'haa, 1'b0, 1'b0);
		send_beat(8'h7f, 1'b0, 1'b1);
	endtask

	task automatic test_random_traffic(input int unsigned idle, input int unsigned stall);
		int unsigned r, len, start;
		sender_idle_pct = idle;
		recv_stall_pct = stall;
		start = random_beats;
		while (random_beats - start < PHASE_BEATS) begin
			r = $urandom_range(99);
			if (r < 70)
				len = $urandom_range(8);
			else if (r < 92)
				len = BOUNDARY_LEN[$urandom_range(7)];
			else
				len = $urandom_range(130);
			r = $urandom_range(1);
			send_message(len, r[0]);
			random_beats += len + ((len == 0 || !r[0]) ? 1 : 0);
		end
		wait_drained(0);
	endtask

	initial begin
		restart_hash();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_empty_message();
		test_short_messages();
		test_ignored_beats();
		wait_drained(0);
		test_random_traffic(0, 0);
		test_random_traffic(66, 0);
		test_random_traffic(0, 66);
		test_random_traffic(33, 33);
		wait_drained(TAIL_CYCLES);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/sha256_pkg.sv
rtl/sha256_front.sv
rtl/sha256_fifo.sv
rtl/sha256_core.sv
rtl/sha256_stream_hash.sv
rtl/sha256_chk.sv
dv/testbench.sv
